>>> sv/msc_pkg.sv
// Shared types and constants for the motion sleep stage classifier.
package msc_pkg;

  typedef enum logic [1:0] {
    STAGE_AWAKE = 2'd0,
    STAGE_LIGHT = 2'd1,
    STAGE_DEEP  = 2'd2
  } stage_t;

  typedef enum logic [2:0] {
    CFG_EPOCH_MS          = 3'd0,
    CFG_ONSET_MINUTES     = 3'd1,
    CFG_DEEP_THRESHOLD    = 3'd2,
    CFG_LIGHT_THRESHOLD   = 3'd3,
    CFG_NIGHT_START_HOUR  = 3'd4,
    CFG_NIGHT_END_HOUR    = 3'd5,
    CFG_MAX_AWAKE_MINUTES = 3'd6
  } cfg_idx_t;

  localparam int unsigned LEVEL_W = 24;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned HOUR_W  = 5;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 24'd3276800;
  localparam logic [15:0]        KEEP_COEF     = 16'd62259;
  localparam logic [11:0]        NEW_COEF      = 12'd3277;
  localparam logic [15:0]        MS_PER_MINUTE = 16'd60000;
  localparam logic [CNT_W-1:0]   CNT_MAX       = 16'hFFFF;
  localparam logic [7:0]         AWAKE_MAX     = 8'hFF;

  localparam logic [TIME_W-1:0]  EPOCH_MS_RESET     = 32'd60000;
  localparam logic [TIME_W-1:0]  ONSET_MS_RESET     = 32'd600000;
  localparam logic [THR_W-1:0]   DEEP_THR_RESET     = 8'd2;
  localparam logic [THR_W-1:0]   LIGHT_THR_RESET    = 8'd8;
  localparam logic [HOUR_W-1:0]  NIGHT_START_RESET  = 5'd22;
  localparam logic [HOUR_W-1:0]  NIGHT_END_RESET    = 5'd7;
  localparam logic [7:0]         MAX_AWAKE_RESET    = 8'd30;

endpackage

>>> sv/motion_sleep_stage_classifier.sv
// Top level of the motion sleep stage classifier: input register, state update, result register.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_stall     kind, intensity, hour, now_ms
//   out_      output     out_valid / out_stall   sleeping, stage, total/deep/light minutes
//   cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction per cycle unless out_stall; it is held in the input, then the result register.
// The path from the input register through the 24x16 smoothing multiply, the threshold
// compares and the next-state selection to the state and result registers sets the clock.
// Synchronous active-low reset restores the register defaults and the tracker state.
// A stall on the result channel stalls the input register and then the input channel.
module motion_sleep_stage_classifier (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_intensity,
  input  logic [4:0]  in_hour,
  input  logic [31:0] in_now_ms,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sleeping,
  output logic [1:0]  out_stage,
  output logic [15:0] out_total_minutes,
  output logic [15:0] out_deep_minutes,
  output logic [15:0] out_light_minutes,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] epoch_ms_r;
  logic [31:0] onset_ms_r;
  logic [7:0]  deep_thr_r;
  logic [7:0]  light_thr_r;
  logic [4:0]  night_start_r;
  logic [4:0]  night_end_r;
  logic [7:0]  max_awake_r;

  logic        in_vld_r;
  logic        kind_r;
  logic [7:0]  intensity_r;
  logic [4:0]  hour_r;
  logic [31:0] now_r;

  logic [23:0]          level_r, level_nxt;
  logic                 asleep_r, asleep_nxt;
  msc_pkg::stage_t      stage_r, stage_nxt;
  logic [31:0]          lms_r, lms_nxt;
  logic [31:0]          last_seen_r, last_seen_nxt;
  logic [31:0]          last_epoch_r, last_epoch_nxt;
  logic [15:0]          total_r, total_nxt;
  logic [15:0]          deep_r, deep_nxt;
  logic [15:0]          light_r, light_nxt;
  logic [7:0]           awake_r, awake_nxt;

  logic                 out_vld_r;
  logic                 out_sleeping_r;
  msc_pkg::stage_t      out_stage_r;
  logic [15:0]          out_total_r;
  logic [15:0]          out_deep_r;
  logic [15:0]          out_light_r;

  logic        proc_go;
  logic        in_acc;
  logic [39:0] keep_prod;
  logic [19:0] new_prod;
  logic [40:0] acc;
  logic [23:0] level_upd;
  logic        below_light;
  logic        below_deep;
  logic        night;
  logic        epoch_due;
  logic [31:0] low_elapsed;
  logic [7:0]  awake_inc;

  assign cfg_ready = 1'b1;
  assign proc_go   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !proc_go;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_ms_r    <= msc_pkg::EPOCH_MS_RESET;
      onset_ms_r    <= msc_pkg::ONSET_MS_RESET;
      deep_thr_r    <= msc_pkg::DEEP_THR_RESET;
      light_thr_r   <= msc_pkg::LIGHT_THR_RESET;
      night_start_r <= msc_pkg::NIGHT_START_RESET;
      night_end_r   <= msc_pkg::NIGHT_END_RESET;
      max_awake_r   <= msc_pkg::MAX_AWAKE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msc_pkg::CFG_EPOCH_MS:          epoch_ms_r    <= cfg_data;
        msc_pkg::CFG_ONSET_MINUTES:     onset_ms_r    <= 32'(cfg_data[7:0]) *
                                                         32'(msc_pkg::MS_PER_MINUTE);
        msc_pkg::CFG_DEEP_THRESHOLD:    deep_thr_r    <= cfg_data[7:0];
        msc_pkg::CFG_LIGHT_THRESHOLD:   light_thr_r   <= cfg_data[7:0];
        msc_pkg::CFG_NIGHT_START_HOUR:  night_start_r <= cfg_data[4:0];
        msc_pkg::CFG_NIGHT_END_HOUR:    night_end_r   <= cfg_data[4:0];
        msc_pkg::CFG_MAX_AWAKE_MINUTES: max_awake_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (proc_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r      <= in_kind;
      intensity_r <= in_intensity;
      hour_r      <= in_hour;
      now_r       <= in_now_ms;
    end
  end

  assign keep_prod   = 40'(level_r) * 40'(msc_pkg::KEEP_COEF);
  assign new_prod    = 20'(intensity_r) * 20'(msc_pkg::NEW_COEF);
  assign acc         = {1'b0, keep_prod} + {5'b0, new_prod, 16'b0};
  assign level_upd   = acc[39:16];
  assign below_light = level_upd < {light_thr_r, 16'b0};
  assign below_deep  = level_upd < {deep_thr_r, 16'b0};
  assign night       = (hour_r >= night_start_r) || (hour_r < night_end_r);
  assign epoch_due   = (now_r - last_epoch_r) >= epoch_ms_r;
  assign low_elapsed = (lms_r == '0) ? '0 : (now_r - lms_r);
  assign awake_inc   = (awake_r == msc_pkg::AWAKE_MAX) ? awake_r : awake_r + 8'd1;

  always_comb begin
    level_nxt      = level_r;
    asleep_nxt     = asleep_r;
    stage_nxt      = stage_r;
    lms_nxt        = lms_r;
    last_seen_nxt  = last_seen_r;
    last_epoch_nxt = last_epoch_r;
    total_nxt      = total_r;
    deep_nxt       = deep_r;
    light_nxt      = light_r;
    awake_nxt      = awake_r;
    if (kind_r) begin
      total_nxt  = '0;
      deep_nxt   = '0;
      light_nxt  = '0;
      awake_nxt  = '0;
      asleep_nxt = 1'b0;
      stage_nxt  = msc_pkg::STAGE_AWAKE;
      lms_nxt    = '0;
    end else begin
      level_nxt     = level_upd;
      last_seen_nxt = now_r;
      if (last_seen_r == '0) begin
        last_epoch_nxt = now_r;
      end else if (!night) begin
        if (asleep_r) begin
          asleep_nxt = 1'b0;
          stage_nxt  = msc_pkg::STAGE_AWAKE;
        end
      end else if (epoch_due) begin
        last_epoch_nxt = now_r;
        if (!asleep_r) begin
          if (below_light) begin
            if (lms_r == '0) begin
              lms_nxt = now_r;
            end
            if (low_elapsed >= onset_ms_r) begin
              asleep_nxt = 1'b1;
              stage_nxt  = msc_pkg::STAGE_LIGHT;
            end
          end else begin
            lms_nxt = '0;
          end
        end else if (below_deep) begin
          stage_nxt = msc_pkg::STAGE_DEEP;
          deep_nxt  = (deep_r == msc_pkg::CNT_MAX) ? deep_r : deep_r + 16'd1;
          total_nxt = (total_r == msc_pkg::CNT_MAX) ? total_r : total_r + 16'd1;
        end else if (below_light) begin
          stage_nxt = msc_pkg::STAGE_LIGHT;
          light_nxt = (light_r == msc_pkg::CNT_MAX) ? light_r : light_r + 16'd1;
          total_nxt = (total_r == msc_pkg::CNT_MAX) ? total_r : total_r + 16'd1;
        end else begin
          stage_nxt = msc_pkg::STAGE_AWAKE;
          if (awake_inc > max_awake_r) begin
            asleep_nxt = 1'b0;
            awake_nxt  = '0;
          end else begin
            awake_nxt = awake_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= msc_pkg::LEVEL_RESET;
      asleep_r     <= 1'b0;
      stage_r      <= msc_pkg::STAGE_AWAKE;
      lms_r        <= '0;
      last_seen_r  <= '0;
      last_epoch_r <= '0;
      total_r      <= '0;
      deep_r       <= '0;
      light_r      <= '0;
      awake_r      <= '0;
    end else if (proc_go) begin
      level_r      <= level_nxt;
      asleep_r     <= asleep_nxt;
      stage_r      <= stage_nxt;
      lms_r        <= lms_nxt;
      last_seen_r  <= last_seen_nxt;
      last_epoch_r <= last_epoch_nxt;
      total_r      <= total_nxt;
      deep_r       <= deep_nxt;
      light_r      <= light_nxt;
      awake_r      <= awake_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      out_sleeping_r <= asleep_nxt;
      out_stage_r    <= stage_nxt;
      out_total_r    <= total_nxt;
      out_deep_r     <= deep_nxt;
      out_light_r    <= light_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_sleeping      = out_sleeping_r;
  assign out_stage         = out_stage_r;
  assign out_total_minutes = out_total_r;
  assign out_deep_minutes  = out_deep_r;
  assign out_light_minutes = out_light_r;

`ifndef ASSERT_OFF
  a_awake_when_not_asleep: assert property (@(posedge clk) disable iff (!rst_n)
    !asleep_r |-> stage_r == msc_pkg::STAGE_AWAKE)
    else $error("stage is not awake outside a sleep session");

  a_total_covers_stages: assert property (@(posedge clk) disable iff (!rst_n)
    total_r >= deep_r && total_r >= light_r)
    else $error("total minutes below deep or light minutes");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a blocked transaction");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_stall && !proc_go |=> !out_vld_r)
    else $error("result repeated after delivery");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !proc_go |=> $stable(level_r) && $stable(total_r) && $stable(last_seen_r))
    else $error("tracker state changed without a transaction");
`endif

endmodule
